// ===== rtl/wsta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsta_pkg
// Shared types and constants of the waypoint segment time allocator.
// ----------------------------------------------------------------------------
package wsta_pkg;

   localparam int unsigned COORD_W  = 24;
   localparam int unsigned ORIENT_W = 16;
   localparam int unsigned TIME_W   = 24;
   localparam int unsigned INDEX_W  = 7;
   localparam int unsigned CSR_W    = 24;
   localparam int unsigned CSR_IDX_W = 2;

   // Operand widths of the shared divide / square root unit.
   localparam int unsigned DS_OPND_W = 64;
   localparam int unsigned DS_DEN_W  = 48;

   typedef logic signed [COORD_W-1:0]  coord_type;
   typedef logic signed [ORIENT_W-1:0] orient_type;
   typedef logic        [TIME_W-1:0]   time_type;
   typedef logic        [INDEX_W-1:0]  index_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_PIECES   = 2'd0,
      CSR_CLICK_HEIGHT = 2'd1,
      CSR_CRUISE_SPEED = 2'd2,
      CSR_MAX_ACCEL    = 2'd3
   } csr_index_type;

   // Command to the divide / square root unit.
   typedef struct packed {
      logic start;
      logic sqrt_mode;
   } ds_cmd_type;

   // Status from the divide / square root unit.
   typedef struct packed {
      logic busy;
      logic done;
   } ds_stat_type;

endpackage

// ===== rtl/wsta_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsta_req_if
// Waypoint request channel: valid/ready handshake with one waypoint payload.
// ----------------------------------------------------------------------------
interface wsta_req_if;
   logic                 valid;
   logic                 ready;
   wsta_pkg::coord_type  pos_x;
   wsta_pkg::coord_type  pos_y;
   wsta_pkg::orient_type orient_z;

   modport source (output valid, output pos_x, output pos_y, output orient_z, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input orient_z, output ready);
endinterface

// ===== rtl/wsta_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsta_rsp_if
// Segment time response channel: valid/ready handshake with one result.
// ----------------------------------------------------------------------------
interface wsta_rsp_if;
   logic                valid;
   logic                ready;
   wsta_pkg::time_type  segment_time;
   logic                time_valid;
   wsta_pkg::index_type point_index;
   logic                restarted;

   modport source (output valid, output segment_time, output time_valid,
                   output point_index, output restarted, input ready);
   modport sink   (input valid, input segment_time, input time_valid,
                   input point_index, input restarted, output ready);
endinterface

// ===== rtl/waypoint_segment_time_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_segment_time_allocator
// Trapezoidal-profile travel time between consecutive clicked waypoints.
// ----------------------------------------------------------------------------
// Each request transaction carries one waypoint and produces exactly one
// response transaction. The block takes one waypoint at a time: it is ready
// only while its sequencer is idle. A long move runs a 32-step square root
// for the distance and a 64-step division, each followed by a registered done
// strobe that hands the finished value back, besides the multiply, setup and
// start states. A short move adds a second 32-step square root, and the first
// point of a sequence skips the divide / square root unit. A finished result
// may also wait for the response register to free up. The shared divide /
// square root unit retires one quotient or root bit per cycle. A finished
// result waits in the response register, so a new waypoint may be taken while
// the previous response is still pending. Configuration writes must only be
// issued while no transaction is in flight.
// ----------------------------------------------------------------------------
module waypoint_segment_time_allocator #(
   parameter int unsigned MAX_PIECE_BOUND = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   wsta_req_if.sink                           req_if,
   wsta_rsp_if.source                         rsp_if,
   input  logic                               csr_we,
   input  logic [wsta_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wsta_pkg::CSR_W-1:0]         csr_wdata
);

   // The point counter must hold one more than the largest piece limit.
   localparam int unsigned CNT_W = $clog2(MAX_PIECE_BOUND + 2);
   localparam int unsigned LIM_W = (CNT_W > wsta_pkg::INDEX_W) ? CNT_W : wsta_pkg::INDEX_W;
   localparam int unsigned MUL_W = 25;
   localparam int unsigned PRD_W = 2 * MUL_W;

   // One-hot sequencer states.
   typedef enum logic [16:0] {
      ST_IDLE   = 17'h00001,
      ST_ZMUL   = 17'h00002,
      ST_DXMUL  = 17'h00004,
      ST_DYMUL  = 17'h00008,
      ST_DZMUL  = 17'h00010,
      ST_ACC    = 17'h00020,
      ST_R1GO   = 17'h00040,
      ST_R1WAIT = 17'h00080,
      ST_DAMUL  = 17'h00100,
      ST_VVMUL  = 17'h00200,
      ST_AVMUL  = 17'h00400,
      ST_SETUP  = 17'h00800,
      ST_DVGO   = 17'h01000,
      ST_DVWAIT = 17'h02000,
      ST_R2GO   = 17'h04000,
      ST_R2WAIT = 17'h08000,
      ST_DONE   = 17'h10000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [wsta_pkg::INDEX_W-1:0] max_pieces_ff;
   logic [wsta_pkg::CSR_W-1:0]   click_height_ff;
   logic [wsta_pkg::CSR_W-1:0]   cruise_speed_ff;
   logic [wsta_pkg::CSR_W-1:0]   max_accel_ff;

   // Sequence state kept between waypoints.
   logic [wsta_pkg::COORD_W-1:0] prev_x_ff;
   logic [wsta_pkg::COORD_W-1:0] prev_y_ff;
   logic [wsta_pkg::COORD_W-1:0] prev_z_ff;
   logic [CNT_W-1:0]             count_ff;

   // Per-transaction working registers.
   logic [15:0]                  mag_ff;
   logic [MUL_W-1:0]             dx_abs_ff;
   logic [MUL_W-1:0]             dy_abs_ff;
   logic [MUL_W-1:0]             dz_abs_ff;
   logic [wsta_pkg::COORD_W-1:0] z_ff;
   logic [PRD_W-1:0]             prod_ff;
   logic [PRD_W-1:0]             acc_ff;
   logic [MUL_W-1:0]             dist_ff;
   logic [PRD_W-1:0]             da_ff;
   logic [PRD_W-1:0]             vv_ff;
   logic [wsta_pkg::DS_OPND_W-1:0] num_ff;
   logic [wsta_pkg::DS_DEN_W-1:0]  den_ff;
   logic                         short_ff;
   logic                         tvalid_ff;
   logic                         restart_ff;
   logic [wsta_pkg::INDEX_W-1:0] idx_ff;
   wsta_pkg::time_type           time_ff;

   // Response register.
   logic                         rsp_valid_ff;
   wsta_pkg::time_type           rsp_time_ff;
   logic                         rsp_tvalid_ff;
   logic [wsta_pkg::INDEX_W-1:0] rsp_idx_ff;
   logic                         rsp_restart_ff;

   // Zero speed or acceleration is treated as one.
   logic [wsta_pkg::CSR_W-1:0] v_eff;
   logic [wsta_pkg::CSR_W-1:0] a_eff;
   assign v_eff = (cruise_speed_ff == '0) ? wsta_pkg::CSR_W'(1) : cruise_speed_ff;
   assign a_eff = (max_accel_ff == '0) ? wsta_pkg::CSR_W'(1) : max_accel_ff;

   // The piece limit is clamped to the range from one to the bound.
   logic [LIM_W-1:0] limit;
   logic [LIM_W-1:0] mp_ext;
   always_comb begin
      mp_ext = LIM_W'(max_pieces_ff);
      if (mp_ext == '0) begin
         limit = LIM_W'(1);
      end else if (mp_ext > LIM_W'(MAX_PIECE_BOUND)) begin
         limit = LIM_W'(MAX_PIECE_BOUND);
      end else begin
         limit = mp_ext;
      end
   end

   // Sequence bookkeeping for the waypoint being accepted.
   logic             accept;
   logic             restart_now;
   logic [CNT_W-1:0] count_eff;
   assign accept      = req_if.valid && req_if.ready;
   assign restart_now = LIM_W'(count_ff) > limit;
   assign count_eff   = restart_now ? '0 : count_ff;

   // Coordinate differences against the previous waypoint.
   logic signed [wsta_pkg::COORD_W:0] dx;
   logic signed [wsta_pkg::COORD_W:0] dy;
   logic signed [wsta_pkg::COORD_W:0] dz;
   logic [15:0]                       oz;
   assign dx = {req_if.pos_x[wsta_pkg::COORD_W-1], req_if.pos_x}
             - {prev_x_ff[wsta_pkg::COORD_W-1], prev_x_ff};
   assign dy = {req_if.pos_y[wsta_pkg::COORD_W-1], req_if.pos_y}
             - {prev_y_ff[wsta_pkg::COORD_W-1], prev_y_ff};
   assign dz = {1'b0, z_ff} - {1'b0, prev_z_ff};
   assign oz = req_if.orient_z;

   // Height from the registered orientation product, saturated to 24 bits.
   logic [PRD_W-15:0]            z_shift;
   logic [wsta_pkg::COORD_W-1:0] z_sat;
   assign z_shift = prod_ff[PRD_W-1:14];
   assign z_sat   = (|z_shift[PRD_W-15:wsta_pkg::COORD_W]) ? '1
                                                           : z_shift[wsta_pkg::COORD_W-1:0];

   // The one shared multiplier; its product is always registered.
   logic [MUL_W-1:0] mul_a;
   logic [MUL_W-1:0] mul_b;
   always_comb begin
      case (state_ff)
         ST_ZMUL: begin
            mul_a = MUL_W'(mag_ff);
            mul_b = MUL_W'(click_height_ff);
         end
         ST_DXMUL: begin
            mul_a = dx_abs_ff;
            mul_b = dx_abs_ff;
         end
         ST_DYMUL: begin
            mul_a = dy_abs_ff;
            mul_b = dy_abs_ff;
         end
         ST_DZMUL: begin
            mul_a = dz_abs_ff;
            mul_b = dz_abs_ff;
         end
         ST_DAMUL: begin
            mul_a = dist_ff;
            mul_b = MUL_W'(a_eff);
         end
         ST_VVMUL: begin
            mul_a = MUL_W'(v_eff);
            mul_b = MUL_W'(v_eff);
         end
         ST_AVMUL: begin
            mul_a = MUL_W'(a_eff);
            mul_b = MUL_W'(v_eff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Shared divide / square root unit.
   wsta_pkg::ds_cmd_type          ds_cmd;
   wsta_pkg::ds_stat_type         ds_stat;
   logic [wsta_pkg::DS_OPND_W-1:0] ds_operand;
   logic [wsta_pkg::DS_OPND_W-1:0] ds_result;

   always_comb begin
      ds_cmd.start     = (state_ff == ST_R1GO) || (state_ff == ST_DVGO)
                      || (state_ff == ST_R2GO);
      ds_cmd.sqrt_mode = (state_ff != ST_DVGO);
      case (state_ff)
         ST_R1GO: ds_operand = wsta_pkg::DS_OPND_W'(acc_ff);
         ST_DVGO: ds_operand = num_ff;
         default: ds_operand = ds_result;
      endcase
   end

   wsta_divsqrt u_divsqrt (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ds_cmd),
      .operand (ds_operand),
      .divisor (den_ff),
      .stat    (ds_stat),
      .result  (ds_result)
   );

   // Times above the 24-bit range saturate.
   wsta_pkg::time_type res_sat;
   assign res_sat = (|ds_result[wsta_pkg::DS_OPND_W-1:wsta_pkg::TIME_W]) ? '1
                                                   : ds_result[wsta_pkg::TIME_W-1:0];

   // Short moves take the square-root branch: d*a < v*v.
   logic             short_now;
   logic [PRD_W:0]   long_sum;
   assign short_now = da_ff < vv_ff;
   assign long_sum  = {1'b0, vv_ff} + {1'b0, da_ff};

   logic load_rsp;
   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_if.ready);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_ZMUL;
         ST_ZMUL:   state_in = ST_DXMUL;
         ST_DXMUL:  state_in = ST_DYMUL;
         ST_DYMUL:  state_in = tvalid_ff ? ST_DZMUL : ST_DONE;
         ST_DZMUL:  state_in = ST_ACC;
         ST_ACC:    state_in = ST_R1GO;
         ST_R1GO:   state_in = ST_R1WAIT;
         ST_R1WAIT: if (ds_stat.done) state_in = ST_DAMUL;
         ST_DAMUL:  state_in = ST_VVMUL;
         ST_VVMUL:  state_in = ST_AVMUL;
         ST_AVMUL:  state_in = ST_SETUP;
         ST_SETUP:  state_in = ST_DVGO;
         ST_DVGO:   state_in = ST_DVWAIT;
         ST_DVWAIT: if (ds_stat.done) state_in = short_ff ? ST_R2GO : ST_DONE;
         ST_R2GO:   state_in = ST_R2WAIT;
         ST_R2WAIT: if (ds_stat.done) state_in = ST_DONE;
         ST_DONE:   if (load_rsp) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         max_pieces_ff   <= wsta_pkg::INDEX_W'(16);
         click_height_ff <= wsta_pkg::CSR_W'(4096);
         cruise_speed_ff <= wsta_pkg::CSR_W'(4096);
         max_accel_ff    <= wsta_pkg::CSR_W'(4096);
         prev_x_ff       <= '0;
         prev_y_ff       <= '0;
         prev_z_ff       <= '0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               wsta_pkg::CSR_MAX_PIECES:   max_pieces_ff   <= csr_wdata[wsta_pkg::INDEX_W-1:0];
               wsta_pkg::CSR_CLICK_HEIGHT: click_height_ff <= csr_wdata;
               wsta_pkg::CSR_CRUISE_SPEED: cruise_speed_ff <= csr_wdata;
               wsta_pkg::CSR_MAX_ACCEL:    max_accel_ff    <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            prev_x_ff <= req_if.pos_x;
            prev_y_ff <= req_if.pos_y;
            count_ff  <= count_eff + CNT_W'(1);
         end
         // The old height is needed for the z difference until this state.
         if (state_ff == ST_DYMUL) begin
            prev_z_ff <= z_ff;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (accept) begin
         mag_ff     <= oz[15] ? (~oz + 16'd1) : oz;
         dx_abs_ff  <= dx[wsta_pkg::COORD_W] ? MUL_W'(-dx) : MUL_W'(dx);
         dy_abs_ff  <= dy[wsta_pkg::COORD_W] ? MUL_W'(-dy) : MUL_W'(dy);
         restart_ff <= restart_now;
         tvalid_ff  <= (count_eff != '0);
         idx_ff     <= wsta_pkg::INDEX_W'(count_eff);
         time_ff    <= '0;
      end
      case (state_ff)
         ST_DXMUL: z_ff <= z_sat;
         ST_DYMUL: begin
            dz_abs_ff <= dz[wsta_pkg::COORD_W] ? MUL_W'(-dz) : MUL_W'(dz);
            acc_ff    <= prod_ff;
         end
         ST_DZMUL:  acc_ff <= acc_ff + prod_ff;
         ST_ACC:    acc_ff <= acc_ff + prod_ff;
         ST_R1WAIT: if (ds_stat.done) dist_ff <= ds_result[MUL_W-1:0];
         ST_VVMUL:  da_ff <= prod_ff;
         ST_AVMUL:  vv_ff <= prod_ff;
         ST_SETUP: begin
            short_ff <= short_now;
            if (short_now) begin
               num_ff <= wsta_pkg::DS_OPND_W'(dist_ff) << 26;
               den_ff <= wsta_pkg::DS_DEN_W'(a_eff);
            end else begin
               num_ff <= wsta_pkg::DS_OPND_W'(long_sum) << 12;
               den_ff <= prod_ff[wsta_pkg::DS_DEN_W-1:0];
            end
         end
         ST_DVWAIT: if (ds_stat.done && !short_ff) time_ff <= res_sat;
         ST_R2WAIT: if (ds_stat.done) time_ff <= res_sat;
         default: ;
      endcase
      if (load_rsp) begin
         rsp_time_ff    <= time_ff;
         rsp_tvalid_ff  <= tvalid_ff;
         rsp_idx_ff     <= idx_ff;
         rsp_restart_ff <= restart_ff;
      end
   end

   assign req_if.ready        = (state_ff == ST_IDLE);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.segment_time = rsp_time_ff;
   assign rsp_if.time_valid   = rsp_tvalid_ff;
   assign rsp_if.point_index  = rsp_idx_ff;
   assign rsp_if.restarted    = rsp_restart_ff;

   // A waypoint occupies the sequencer, which is then not ready for another.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request accepted while a waypoint was in flight");

   // The first point of a sequence never carries a time.
   a_first_point_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.time_valid) |-> (rsp_if.segment_time == '0))
      else $error("first point of a sequence carries a nonzero time");

   // A restarted sequence always begins at index zero.
   a_restart_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.restarted) |-> (rsp_if.point_index == '0))
      else $error("restarted point has a nonzero index");

   // The shared unit only finishes while the sequencer waits for it.
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      ds_stat.done |-> ((state_ff == ST_R1WAIT) || (state_ff == ST_DVWAIT)
                        || (state_ff == ST_R2WAIT)))
      else $error("divide or root finished outside a wait state");

endmodule

// ===== rtl/wsta_divsqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsta_divsqrt
// Iterative restoring divider and digit-by-digit square root on one subtractor.
// ----------------------------------------------------------------------------
module wsta_divsqrt (
   input  logic                                clock,
   input  logic                                reset,
   input  wsta_pkg::ds_cmd_type                cmd,
   input  logic [wsta_pkg::DS_OPND_W-1:0]      operand,
   input  logic [wsta_pkg::DS_DEN_W-1:0]       divisor,
   output wsta_pkg::ds_stat_type               stat,
   output logic [wsta_pkg::DS_OPND_W-1:0]      result
);

   localparam int unsigned REM_W = wsta_pkg::DS_DEN_W + 1;

   logic                              busy_ff;
   logic                              done_ff;
   logic                              sqrt_ff;
   logic [5:0]                        cnt_ff;
   logic [REM_W-1:0]                  rem_ff;
   logic [wsta_pkg::DS_OPND_W-1:0]    src_ff;
   logic [wsta_pkg::DS_OPND_W-1:0]    quo_ff;
   logic [wsta_pkg::DS_DEN_W-1:0]     den_ff;

   logic [REM_W-1:0] rem_sh;
   logic [REM_W-1:0] trial;
   logic [REM_W:0]   diff;
   logic             ge;
   logic             last;

   // Division brings down one numerator bit per step, square root two.
   always_comb begin
      if (sqrt_ff) begin
         rem_sh = {rem_ff[REM_W-3:0], src_ff[wsta_pkg::DS_OPND_W-1 -: 2]};
         trial  = {{(REM_W-34){1'b0}}, quo_ff[31:0], 2'b01};
      end else begin
         rem_sh = {rem_ff[REM_W-2:0], src_ff[wsta_pkg::DS_OPND_W-1]};
         trial  = {1'b0, den_ff};
      end
      diff = {1'b0, rem_sh} - {1'b0, trial};
      ge   = ~diff[REM_W];
      last = (cnt_ff == (sqrt_ff ? 6'd31 : 6'd63));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && last) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         sqrt_ff <= cmd.sqrt_mode;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         quo_ff  <= '0;
         src_ff  <= operand;
         den_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[REM_W-1:0] : rem_sh;
         quo_ff <= {quo_ff[wsta_pkg::DS_OPND_W-2:0], ge};
         src_ff <= sqrt_ff ? (src_ff << 2) : (src_ff << 1);
         cnt_ff <= cnt_ff + 6'd1;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = quo_ff;

endmodule

// ===== bench/waypoint_segment_time_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_segment_time_allocator_test
// Self-checking bench for the waypoint segment time allocator.
// ----------------------------------------------------------------------------
// Waypoints are sent over the request channel and every response transaction
// is compared field by field with a travel time worked out by a bit-exact
// model of the trapezoidal allocation kept inside this bench. Directed tests
// cover coordinate and orientation extremes, the register corner cases and a
// lowered piece limit. Random traffic then runs in three phases with
// different idling on each side of the block.
// ----------------------------------------------------------------------------
module waypoint_segment_time_allocator_test;

   localparam int unsigned PIECE_BOUND = 64;
   localparam longint unsigned MASK24 = 64'hFF_FFFF;

   typedef struct {
      wsta_pkg::time_type  segment_time;
      logic                time_valid;
      wsta_pkg::index_type point_index;
      logic                restarted;
   } segment_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [wsta_pkg::CSR_IDX_W-1:0] csr_index;
   logic [wsta_pkg::CSR_W-1:0] csr_wdata;

   wsta_req_if req_ch ();
   wsta_rsp_if rsp_ch ();

   waypoint_segment_time_allocator #(.MAX_PIECE_BOUND(PIECE_BOUND)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register shadow copies used by the time model.
   int unsigned piece_limit_reg;
   longint unsigned height_reg;
   longint unsigned speed_reg;
   longint unsigned accel_reg;

   // Model copy of the previous waypoint and the point count.
   longint trail_x;
   longint trail_y;
   longint unsigned trail_z;
   int unsigned trail_count;

   segment_result_type pending_times[$];
   int unsigned fail_count;
   int unsigned send_gap_pct;
   int unsigned recv_stall_pct;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The run is far shorter than this even with the heaviest stalls.
   initial begin
      #40ms;
      $display("CHECK FAILED");
      $finish;
   end

   // Integer square root, one result bit per pass.
   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // Travel time of one segment of length seg_len under the trapezoidal
   // profile. The ramp test compares seg_len*a with v*v so no fraction is lost.
   function automatic longint unsigned ramp_time(longint unsigned seg_len,
                                                 longint unsigned v,
                                                 longint unsigned a);
      longint unsigned t;
      if (seg_len * a < v * v) t = int_sqrt((seg_len << 26) / a);
      else t = ((v * v + seg_len * a) << 12) / (a * v);
      return (t > MASK24) ? MASK24 : t;
   endfunction

   // Advances the model by one waypoint and returns the expected response.
   function automatic segment_result_type allocate_segment(wsta_pkg::coord_type px,
                                                           wsta_pkg::coord_type py,
                                                           wsta_pkg::orient_type oz);
      segment_result_type r;
      int unsigned limit;
      longint unsigned v, a, mag, z, sq;
      longint dx, dy, dz;
      limit = piece_limit_reg;
      if (limit < 1) limit = 1;
      if (limit > PIECE_BOUND) limit = PIECE_BOUND;
      v = (speed_reg == 0) ? 1 : speed_reg;
      a = (accel_reg == 0) ? 1 : accel_reg;
      // A magnitude of 32768 for the most negative code is kept as is.
      mag = (oz < 0) ? longint'(-longint'(oz)) : longint'(oz);
      z = (mag * height_reg) >> 14;
      if (z > MASK24) z = MASK24;
      r.segment_time = '0;
      r.time_valid = 1'b0;
      r.restarted = 1'b0;
      if (trail_count > limit) begin
         trail_count = 0;
         r.restarted = 1'b1;
      end
      if (trail_count > 0) begin
         dx = longint'(px) - trail_x;
         dy = longint'(py) - trail_y;
         dz = longint'(z) - longint'(trail_z);
         sq = dx * dx + dy * dy + dz * dz;
         r.segment_time = wsta_pkg::time_type'(ramp_time(int_sqrt(sq), v, a));
         r.time_valid = 1'b1;
      end
      r.point_index = wsta_pkg::index_type'(trail_count);
      trail_x = longint'(px);
      trail_y = longint'(py);
      trail_z = z;
      trail_count++;
      return r;
   endfunction

   // Sends one waypoint; valid stays high after acceptance so that
   // back-to-back transactions need no extra cycle.
   task automatic send_waypoint(wsta_pkg::coord_type px, wsta_pkg::coord_type py,
                                wsta_pkg::orient_type oz);
      int unsigned gap;
      if ($urandom_range(99) < send_gap_pct) begin
         gap = $urandom_range(1, 8);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pos_x <= px;
      req_ch.pos_y <= py;
      req_ch.orient_z <= oz;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_times.push_back(allocate_segment(px, py, oz));
   endtask

   // Lowers valid in the step of the last acceptance and waits until every
   // response is in, then waits further for the sequencer to go idle.
   task automatic drain_block();
      req_ch.valid <= 1'b0;
      while (pending_times.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // The enable is lowered again after each write so that back-to-back writes
   // never drive the enable twice in one step.
   task automatic write_register(wsta_pkg::csr_index_type idx,
                                 logic [wsta_pkg::CSR_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         wsta_pkg::CSR_MAX_PIECES:
            piece_limit_reg = 32'(value[wsta_pkg::INDEX_W-1:0]);
         wsta_pkg::CSR_CLICK_HEIGHT: height_reg = 64'(value);
         wsta_pkg::CSR_CRUISE_SPEED: speed_reg = 64'(value);
         wsta_pkg::CSR_MAX_ACCEL:    accel_reg = 64'(value);
         default: ;
      endcase
   endtask

   task automatic write_all(int unsigned pieces, logic [wsta_pkg::CSR_W-1:0] height,
                            logic [wsta_pkg::CSR_W-1:0] speed,
                            logic [wsta_pkg::CSR_W-1:0] accel);
      write_register(wsta_pkg::CSR_MAX_PIECES, wsta_pkg::CSR_W'(pieces));
      write_register(wsta_pkg::CSR_CLICK_HEIGHT, height);
      write_register(wsta_pkg::CSR_CRUISE_SPEED, speed);
      write_register(wsta_pkg::CSR_MAX_ACCEL, accel);
   endtask

   // The receiver stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Every accepted response is matched against the oldest expectation.
   always @(posedge clock) begin
      segment_result_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_times.size() == 0) begin
            $error("response transaction with no waypoint outstanding");
            fail_count++;
         end else begin
            e = pending_times.pop_front();
            if (rsp_ch.segment_time !== e.segment_time) begin
               $error("segment_time expected %0d actual %0d", e.segment_time,
                      rsp_ch.segment_time);
               fail_count++;
            end
            if (rsp_ch.time_valid !== e.time_valid) begin
               $error("time_valid expected %0d actual %0d", e.time_valid,
                      rsp_ch.time_valid);
               fail_count++;
            end
            if (rsp_ch.point_index !== e.point_index) begin
               $error("point_index expected %0d actual %0d", e.point_index,
                      rsp_ch.point_index);
               fail_count++;
            end
            if (rsp_ch.restarted !== e.restarted) begin
               $error("restarted expected %0d actual %0d", e.restarted,
                      rsp_ch.restarted);
               fail_count++;
            end
         end
      end
   end

   // Coordinate and orientation extremes under the reset register values,
   // then with a large height scale so that z saturates.
   task automatic test_field_extremes();
      send_waypoint(24'sh000000, 24'sh000000, 16'sh0000);
      send_waypoint(24'sh7FFFFF, 24'sh7FFFFF, 16'sh4000);
      send_waypoint(-24'sh800000, -24'sh800000, -16'sh4000);
      send_waypoint(24'sh7FFFFF, -24'sh800000, 16'sh7FFF);
      send_waypoint(24'sh000001, 24'sh000000, -16'sh8000);
      send_waypoint(24'sh000001, 24'sh000000, -16'sh8000);
      send_waypoint(24'sh000002, 24'sh000001, 16'sh0001);
      drain_block();
      write_register(wsta_pkg::CSR_CLICK_HEIGHT, 24'hFFFFFF);
      send_waypoint(24'sh000000, 24'sh000000, -16'sh8000);
      send_waypoint(-24'sh800000, 24'sh7FFFFF, 16'sh0000);
      send_waypoint(24'sh7FFFFF, -24'sh800000, -16'sh8000);
      drain_block();
   endtask

   // Zero speed and acceleration act as one, out-of-range piece limits clamp.
   task automatic test_register_corners();
      write_all(0, '0, '0, '0);
      send_waypoint(24'sh000100, 24'sh000000, 16'sh0000);
      send_waypoint(24'sh000000, 24'sh000000, 16'sh0000);
      send_waypoint(24'sh7FFFFF, 24'sh7FFFFF, 16'sh0000);
      send_waypoint(24'sh7FFFFF, 24'sh7FFFFF, 16'sh0000);
      drain_block();
      write_all(127, 24'h001000, 24'hFFFFFF, 24'h000001);
      send_waypoint(24'sh001000, 24'sh000000, 16'sh2000);
      send_waypoint(-24'sh800000, 24'sh000000, 16'sh2000);
      drain_block();
      write_all(PIECE_BOUND, 24'h000800, 24'h000001, 24'hFFFFFF);
      for (int i = 0; i < 4; i++)
         send_waypoint(wsta_pkg::coord_type'($urandom), wsta_pkg::coord_type'($urandom),
                       wsta_pkg::orient_type'($urandom));
      drain_block();
   endtask

   // A long sequence with the piece limit lowered under the current count:
   // the next point must begin a new sequence.
   task automatic test_lowered_limit();
      write_all(16, 24'h001000, 24'h001000, 24'h001000);
      for (int i = 0; i < 10; i++)
         send_waypoint(wsta_pkg::coord_type'(i * 4096), wsta_pkg::coord_type'(-i * 2048),
                       16'sh1000);
      drain_block();
      write_register(wsta_pkg::CSR_MAX_PIECES, wsta_pkg::CSR_W'(3));
      send_waypoint(24'sh000000, 24'sh000000, 16'sh0000);
      send_waypoint(24'sh004000, 24'sh000000, 16'sh0000);
      drain_block();
   endtask

   // Random waypoints, mostly close to the previous one so that times are
   // spread over both ramp cases, and sometimes anywhere in the field.
   task automatic test_random_traffic(int unsigned items);
      wsta_pkg::coord_type px, py;
      wsta_pkg::orient_type oz;
      px = '0;
      py = '0;
      for (int i = 0; i < items; i++) begin
         if (i % 100 == 0) begin
            drain_block();
            case ($urandom_range(3))
               0: write_all($urandom_range(1, 6), wsta_pkg::CSR_W'($urandom),
                            wsta_pkg::CSR_W'($urandom_range(1, 24'h4000)),
                            wsta_pkg::CSR_W'($urandom_range(1, 24'h4000)));
               1: write_all($urandom_range(0, 127), wsta_pkg::CSR_W'($urandom),
                            wsta_pkg::CSR_W'($urandom), wsta_pkg::CSR_W'($urandom));
               2: write_all(PIECE_BOUND, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
               default: write_all(1, wsta_pkg::CSR_W'($urandom_range(0, 24'h2000)),
                                  wsta_pkg::CSR_W'($urandom_range(0, 3)),
                                  wsta_pkg::CSR_W'($urandom_range(0, 3)));
            endcase
         end
         if ($urandom_range(3) == 0) begin
            px = wsta_pkg::coord_type'($urandom);
            py = wsta_pkg::coord_type'($urandom);
         end else begin
            px = px + wsta_pkg::coord_type'($urandom_range(0, 24'h3FFFF)) - 24'sh20000;
            py = py + wsta_pkg::coord_type'($urandom_range(0, 24'h3FFFF)) - 24'sh20000;
         end
         oz = wsta_pkg::orient_type'($urandom);
         send_waypoint(px, py, oz);
      end
      drain_block();
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.orient_z = '0;
      rsp_ch.ready = 1'b0;
      fail_count = 0;
      send_gap_pct = 6;
      recv_stall_pct = 51;
      piece_limit_reg = 16;
      height_reg = 4096;
      speed_reg = 4096;
      accel_reg = 4096;
      trail_x = 0;
      trail_y = 0;
      trail_z = 0;
      trail_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      test_field_extremes();
      test_register_corners();
      test_lowered_limit();

      test_random_traffic(430);
      send_gap_pct = 51;
      recv_stall_pct = 6;
      test_random_traffic(430);
      send_gap_pct = 0;
      recv_stall_pct = 0;
      test_random_traffic(430);

      repeat (200) @(posedge clock);
      if (pending_times.size() != 0) begin
         $error("%0d responses never arrived", pending_times.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
